>>> rtl/signed_fixed_to_decimal_text_defines.svh
//------------------------------------------------------------------------------
// Assertion macros for the decimal text converter
// Short forms for clocked implications. Both expect signals named clk and
// arst_n in the scope where they are used.
//------------------------------------------------------------------------------
`ifndef SIGNED_FIXED_TO_DECIMAL_TEXT_DEFINES_SVH
`define SIGNED_FIXED_TO_DECIMAL_TEXT_DEFINES_SVH

// Same-cycle implication.
`define SFDT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("sfdt checker: assertion failed");

// Next-cycle implication.
`define SFDT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("sfdt checker: assertion failed");

`endif

>>> rtl/sfdt_pkg.sv
//------------------------------------------------------------------------------
// sfdt_pkg
// Shared constants, character codes and controller/datapath signal groups.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfdt_pkg;

	localparam int INT_BITS_DEF  = 24;
	localparam int FRAC_BITS_DEF = 7;
	localparam int MAX_RESULTS   = 17;
	localparam int WORD_W        = 32;
	localparam int CHAR_W        = 8;
	localparam int CHAR_CNT_W    = $clog2(MAX_RESULTS);

	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] ASCII_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;

	typedef enum logic [1:0] {
		CH_SIGN,
		CH_INT,
		CH_DOT,
		CH_FRAC
	} char_sel_t;

	typedef struct packed {
		logic      load;
		logic      dabble;
		logic      find;
		logic      emit;
		logic      last;
		char_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic sign;
		logic idx_zero;
		logic frac_zero;
		logic frac_next_zero;
		logic out_free;
	} dp_status_t;

	// Upper bound on the decimal digits of a value of the given bit width.
	function automatic int dec_digits(input int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/sfdt_channels.sv
//------------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for the input word and the output characters.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfdt_word_if;
	logic                         valid;
	logic                         ready;
	logic [sfdt_pkg::WORD_W-1:0]  word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface sfdt_char_if;
	logic                         valid;
	logic                         ready;
	logic [sfdt_pkg::CHAR_W-1:0]  char_code;
	logic                         last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

>>> rtl/signed_fixed_to_decimal_text.sv
// Converts one sign-magnitude fixed-point word (sign above INT_BITS integer bits
// above FRAC_BITS fraction bits) into ASCII decimal text, one character per
// output transfer, with last_char set on the final character. After a word is
// taken, a shift-and-add-3 converter shifts through the integer bits in turn,
// a separate step picks the leading digit, and then one character leaves per
// cycle while the output side keeps up; the block is ready for the next word
// as soon as its last character is loaded into the output register. At most
// 17 characters are produced per word.
//------------------------------------------------------------------------------
// signed_fixed_to_decimal_text
// Top level: joins the sequencer and the datapath to the channel interfaces.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_fixed_to_decimal_text #(
	parameter int INT_BITS  = sfdt_pkg::INT_BITS_DEF,
	parameter int FRAC_BITS = sfdt_pkg::FRAC_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sfdt_word_if.sink  word_in,
	sfdt_char_if.source char_out
);
	import sfdt_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	sfdt_ctrl #(
		.INT_BITS (INT_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (word_in.valid),
		.in_ready (word_in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	sfdt_datapath #(
		.INT_BITS  (INT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.word      (word_in.word),
		.cmd       (cmd),
		.status    (status),
		.out_valid (char_out.valid),
		.out_ready (char_out.ready),
		.char_code (char_out.char_code),
		.last_char (char_out.last_char)
	);

endmodule

`default_nettype wire

>>> rtl/sfdt_ctrl.sv
//------------------------------------------------------------------------------
// sfdt_ctrl
// Sequencer: loads a word, runs the binary to BCD conversion, then steps
// through sign (negative words only), integer digits, point and fraction digits.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfdt_ctrl #(
	parameter int INT_BITS = sfdt_pkg::INT_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire sfdt_pkg::dp_status_t status,
	output sfdt_pkg::dp_cmd_t         cmd
);
	import sfdt_pkg::*;

	localparam int CNT_W = (INT_BITS > 1) ? $clog2(INT_BITS) : 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CONV = 7'b0000010,
		ST_FIND = 7'b0000100,
		ST_SIGN = 7'b0001000,
		ST_INT  = 7'b0010000,
		ST_DOT  = 7'b0100000,
		ST_FRAC = 7'b1000000
	} state_t;

	state_t                state_q;
	state_t                state_d;
	logic [CNT_W-1:0]      bit_cnt_q;
	logic [CHAR_CNT_W-1:0] char_cnt_q;
	logic                  trunc;

	always_comb begin
		trunc    = (char_cnt_q == CHAR_CNT_W'(MAX_RESULTS - 1));
		cmd      = '0;
		cmd.sel  = CH_SIGN;
		in_ready = (state_q == ST_IDLE);
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				cmd.find = 1'b1;
				state_d  = status.sign ? ST_SIGN : ST_INT;
			end
			ST_SIGN: begin
				cmd.sel  = CH_SIGN;
				cmd.emit = status.out_free;
				cmd.last = trunc;
				if (cmd.emit) begin
					state_d = trunc ? ST_IDLE : ST_INT;
				end
			end
			ST_INT: begin
				cmd.sel  = CH_INT;
				cmd.emit = status.out_free;
				cmd.last = trunc;
				if (cmd.emit) begin
					if (trunc) begin
						state_d = ST_IDLE;
					end else if (status.idx_zero) begin
						state_d = ST_DOT;
					end
				end
			end
			ST_DOT: begin
				cmd.sel  = CH_DOT;
				cmd.emit = status.out_free;
				cmd.last = trunc;
				if (cmd.emit) begin
					state_d = trunc ? ST_IDLE : ST_FRAC;
				end
			end
			ST_FRAC: begin
				cmd.sel  = CH_FRAC;
				cmd.emit = status.out_free;
				cmd.last = trunc || status.frac_zero || status.frac_next_zero;
				if (cmd.emit && cmd.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bit_cnt_q  <= '0;
			char_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				bit_cnt_q  <= CNT_W'(INT_BITS - 1);
				char_cnt_q <= '0;
			end else begin
				if (cmd.dabble) begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
				end
				if (cmd.emit) begin
					char_cnt_q <= char_cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/sfdt_datapath.sv
//------------------------------------------------------------------------------
// sfdt_datapath
// Word fields, shift-and-add-3 BCD converter, fraction times-ten step and the
// output character register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfdt_datapath #(
	parameter int INT_BITS  = sfdt_pkg::INT_BITS_DEF,
	parameter int FRAC_BITS = sfdt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [sfdt_pkg::WORD_W-1:0] word,
	input  wire sfdt_pkg::dp_cmd_t           cmd,
	output sfdt_pkg::dp_status_t             status,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [sfdt_pkg::CHAR_W-1:0]      char_code,
	output logic                             last_char
);
	import sfdt_pkg::*;

	localparam int ND    = dec_digits(INT_BITS);
	localparam int IDX_W = (ND > 1) ? $clog2(ND) : 1;
	localparam int EXT_W = 2 * WORD_W;
	localparam int PRD_W = FRAC_BITS + 4;

	logic                 sign_q;
	logic [INT_BITS-1:0]  ip_q;
	logic [3:0]           dig_q [ND];
	logic [IDX_W-1:0]     idx_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;

	logic [EXT_W-1:0]     ext;
	logic [3:0]           adj [ND];
	logic                 carry [ND];
	logic [IDX_W-1:0]     top;
	logic [PRD_W-1:0]     prod;
	logic [CHAR_W-1:0]    char_d;

	always_comb begin
		ext  = EXT_W'(word);
		prod = (PRD_W'(frac_q) << 3) + (PRD_W'(frac_q) << 1);
		top  = '0;
		for (int i = 0; i < ND; i++) begin
			adj[i] = (dig_q[i] >= 4'd5) ? (dig_q[i] + 4'd3) : dig_q[i];
			if (dig_q[i] != 4'd0) begin
				top = IDX_W'(i);
			end
		end
		carry[0] = ip_q[INT_BITS-1];
		for (int i = 1; i < ND; i++) begin
			carry[i] = adj[i-1][3];
		end
		case (cmd.sel)
			CH_SIGN: char_d = ASCII_MINUS;
			CH_INT:  char_d = ASCII_ZERO + CHAR_W'(dig_q[idx_q]);
			CH_DOT:  char_d = ASCII_DOT;
			CH_FRAC: char_d = (frac_q == '0) ? ASCII_ZERO
			                                 : ASCII_ZERO + CHAR_W'(prod[PRD_W-1:FRAC_BITS]);
			default: char_d = ASCII_DOT;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sign_q <= ext[INT_BITS + FRAC_BITS];
			ip_q   <= INT_BITS'(ext >> FRAC_BITS);
			frac_q <= word[FRAC_BITS-1:0];
			for (int i = 0; i < ND; i++) begin
				dig_q[i] <= 4'd0;
			end
		end else begin
			if (cmd.dabble) begin
				ip_q <= ip_q << 1;
				for (int i = 0; i < ND; i++) begin
					dig_q[i] <= {adj[i][2:0], carry[i]};
				end
			end
			if (cmd.emit && (cmd.sel == CH_FRAC)) begin
				frac_q <= prod[FRAC_BITS-1:0];
			end
		end
		if (cmd.find) begin
			idx_q <= top;
		end else if (cmd.emit && (cmd.sel == CH_INT)) begin
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.emit) begin
			char_q <= char_d;
			last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status.sign           = sign_q;
		status.idx_zero       = (idx_q == '0);
		status.frac_zero      = (frac_q == '0);
		status.frac_next_zero = (prod[FRAC_BITS-1:0] == '0);
		status.out_free       = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule

`default_nettype wire

>>> rtl/sfdt_checker.sv
//------------------------------------------------------------------------------
// sfdt_checker
// Port-level checks on the decimal text converter, bound to its top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "signed_fixed_to_decimal_text_defines.svh"

module sfdt_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [sfdt_pkg::CHAR_W-1:0] char_code,
	input wire logic                        last_char
);
	import sfdt_pkg::*;

	// A stalled character must stay put.
	`SFDT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_code) && $stable(last_char))

	// A word that has just been taken leaves the input not ready.
	`SFDT_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)

	// While a character that is not the last one waits, the word is still in work.
	`SFDT_ASSERT_IMP(a_no_take_mid_text, out_valid && !last_char, !in_ready)

	// Only sign, point and decimal digits are ever shown.
	`SFDT_ASSERT_IMP(a_legal_char, out_valid, (char_code == ASCII_MINUS) || (char_code == ASCII_DOT) || ((char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE)))

endmodule

bind signed_fixed_to_decimal_text sfdt_checker u_sfdt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (word_in.valid),
	.in_ready  (word_in.ready),
	.out_valid (char_out.valid),
	.out_ready (char_out.ready),
	.char_code (char_out.char_code),
	.last_char (char_out.last_char)
);

`default_nettype wire

>>> bench/signed_fixed_to_decimal_text_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// signed_fixed_to_decimal_text_tb
// Self-checking bench for the fixed-point to decimal text converter. A queue of
// words, first hand-picked corner values and then random words, feeds a clocked
// driver. Each accepted word is turned into its expected character string by a
// local predictor. A clocked monitor compares every character transfer with the
// oldest expected character. Sender and receiver idle at varying rates, and one
// long receiver hold-off makes the block back up into its input.
//------------------------------------------------------------------------------
module signed_fixed_to_decimal_text_tb;
	import sfdt_pkg::*;

	localparam int RANDOM_WORDS = 394;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 200;
	localparam int PHASE_LEN    = 48;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SIGN_POS     = INT_BITS_DEF + FRAC_BITS_DEF;
	localparam int FRAC_EXT_W   = FRAC_BITS_DEF + 4;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              is_last;
	} text_char_t;

	logic clk;
	logic arst_n;

	sfdt_word_if word_ch ();
	sfdt_char_if char_ch ();

	signed_fixed_to_decimal_text i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.word_in  (word_ch),
		.char_out (char_ch)
	);

	logic [WORD_W-1:0] pending_words[$];
	text_char_t        expected_text[$];
	text_char_t        next_char;
	int                words_taken;
	int                chars_seen;
	int                errors;
	int                negative_words;
	int                zero_fractions;
	int                longest_text;
	int                hold_left;
	int                hold_total;
	bit                hold_done;
	int                cycles;

	always #10 clk = ~clk;

	function automatic int idle_phase();
		if (words_taken < 25) begin
			return 0;
		end
		return ((words_taken - 25) / PHASE_LEN) % 4;
	endfunction

	function automatic int sender_idle_pct();
		case (idle_phase())
			1: begin
				return 49;
			end
			3: begin
				return 16;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (idle_phase())
			2: begin
				return 49;
			end
			3: begin
				return 16;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	// Appends the characters of one word's decimal text to the expected queue.
	function automatic void render_text(input logic [WORD_W-1:0] w);
		logic [INT_BITS_DEF-1:0]    ipart;
		logic [FRAC_EXT_W-1:0]      frac;
		logic [CHAR_W-1:0]          text[$];
		logic [CHAR_W-1:0]          digits[$];
		int                         n;
		ipart = w[SIGN_POS-1:FRAC_BITS_DEF];
		frac = FRAC_EXT_W'(w[FRAC_BITS_DEF-1:0]);
		if (w[SIGN_POS]) begin
			text.push_back(ASCII_MINUS);
			negative_words++;
		end
		do begin
			digits.push_front(ASCII_ZERO + CHAR_W'(ipart % 10));
			ipart = INT_BITS_DEF'(ipart / 10);
		end while (ipart != 0);
		foreach (digits[k]) begin
			text.push_back(digits[k]);
		end
		text.push_back(ASCII_DOT);
		if (frac == 0) begin
			text.push_back(ASCII_ZERO);
			zero_fractions++;
		end else begin
			for (int i = 0; i < FRAC_BITS_DEF && frac != 0; i++) begin
				frac = FRAC_EXT_W'(frac * 10);
				text.push_back(ASCII_ZERO + CHAR_W'(frac >> FRAC_BITS_DEF));
				frac = frac & FRAC_EXT_W'((1 << FRAC_BITS_DEF) - 1);
			end
		end
		n = (text.size() > MAX_RESULTS) ? MAX_RESULTS : text.size();
		if (n > longest_text) begin
			longest_text = n;
		end
		for (int k = 0; k < n; k++) begin
			expected_text.push_back('{code: text[k], is_last: (k == n - 1)});
		end
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		logic [INT_BITS_DEF-1:0]  ipart;
		logic [FRAC_BITS_DEF-1:0] frac;
		int                       pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			return $urandom;
		end
		ipart = INT_BITS_DEF'($urandom & ((32'd1 << $urandom_range(0, INT_BITS_DEF)) - 1));
		case ($urandom_range(0, 3))
			0: begin
				frac = '0;
			end
			1: begin
				frac = FRAC_BITS_DEF'(1) << $urandom_range(0, FRAC_BITS_DEF - 1);
			end
			default: begin
				frac = FRAC_BITS_DEF'($urandom);
			end
		endcase
		return {$urandom_range(0, 1) == 1, ipart, frac};
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			word_ch.valid <= 1'b0;
		end else begin
			if (word_ch.valid && word_ch.ready) begin
				render_text(word_ch.word);
				words_taken++;
			end
			if (!word_ch.valid || word_ch.ready) begin
				if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
					word_ch.valid <= 1'b1;
					word_ch.word <= pending_words.pop_front();
				end else begin
					word_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			char_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			char_ch.ready <= 1'b0;
		end else if (!hold_done && words_taken >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_total <= hold_total + HOLD_CYCLES;
			char_ch.ready <= 1'b0;
		end else begin
			char_ch.ready <= $urandom_range(0, 99) >= receiver_stall_pct();
		end
	end

	always @(posedge clk) begin
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (expected_text.size() == 0) begin
				$error("char_code: no character expected, got %h", char_ch.char_code);
				errors++;
			end else begin
				next_char = expected_text.pop_front();
				chars_seen++;
				if (char_ch.char_code !== next_char.code) begin
					$error("char_code mismatch: expected %h, actual %h",
						next_char.code, char_ch.char_code);
					errors++;
				end
				if (char_ch.last_char !== next_char.is_last) begin
					$error("last_char mismatch: expected %b, actual %b",
						next_char.is_last, char_ch.last_char);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		word_ch.valid = 1'b0;
		word_ch.word = '0;
		char_ch.ready = 1'b0;
		words_taken = 0;
		chars_seen = 0;
		errors = 0;
		negative_words = 0;
		zero_fractions = 0;
		longest_text = 0;
		hold_left = 0;
		hold_total = 0;
		hold_done = 1'b0;
		cycles = 0;

		pending_words.push_back(32'h0000_0000);
		pending_words.push_back(32'h8000_0000);
		pending_words.push_back(32'h7FFF_FFFF);
		pending_words.push_back(32'hFFFF_FFFF);
		pending_words.push_back(32'h0000_0001);
		pending_words.push_back(32'h8000_0001);
		pending_words.push_back(32'h0000_007F);
		pending_words.push_back(32'h0000_0040);
		pending_words.push_back(32'h0000_0080);
		pending_words.push_back(32'h8000_0080);
		pending_words.push_back(32'h0000_0500);
		pending_words.push_back(32'h7FFF_FF80);
		pending_words.push_back(32'hFFFF_FF80);
		pending_words.push_back(32'h0000_0041);
		pending_words.push_back(32'h0000_04E0);
		pending_words.push_back(32'h8032_0020);
		pending_words.push_back(32'h4000_0000);
		pending_words.push_back(32'h0001_86A0);
		pending_words.push_back(32'h2AAA_AAAA);
		pending_words.push_back(32'hD555_5555);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			pending_words.push_back(random_word());
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() > 0 || word_ch.valid || expected_text.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d words into %0d characters, longest text %0d characters.",
			words_taken, chars_seen, longest_text);
		$display("Negative words %0d, zero fractions %0d, receiver hold-off %0d cycles.",
			negative_words, zero_fractions, hold_total);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/sfdt_pkg.sv
rtl/sfdt_channels.sv
rtl/sfdt_ctrl.sv
rtl/sfdt_datapath.sv
rtl/signed_fixed_to_decimal_text.sv
rtl/sfdt_checker.sv
bench/signed_fixed_to_decimal_text_tb.sv
